// ----- src/rmst_pkg.sv -----
// Shared widths, codes and constants of the range-minimum segment tree.
`default_nettype none

package rmst_pkg;

	localparam int VAL_W  = 61;            // node value width, two's complement
	localparam int CFG_W  = 11;            // leaf count register width
	localparam int IDX_W  = 10;            // update index width
	localparam int NODE_W = CFG_W + 1;     // node number, holds up to 2*leaf_count

	localparam logic [CFG_W-1:0] LEAF_RESET = CFG_W'(1024);

	localparam logic signed [VAL_W-1:0] SENTINEL = 61'sd1000000000000000000;

	localparam logic MODE_UPDATE = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

endpackage

`default_nettype wire

// ----- src/rmst_min_unit.sv -----
// Shared signed minimum unit used by both update and query sequences.
`default_nettype none

module rmst_min_unit (
	input  wire logic signed [rmst_pkg::VAL_W-1:0] a,
	input  wire logic signed [rmst_pkg::VAL_W-1:0] b,
	output logic signed [rmst_pkg::VAL_W-1:0]      y
);

	always_comb begin
		if (b < a) begin
			y = b;
		end else begin
			y = a;
		end
	end

endmodule

`default_nettype wire

// ----- src/range_min_segment_tree_unit.sv -----
// Top level: bottom-up range-minimum segment tree with a node store and sequencer.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  in       | in_valid, in_ready, mode, update_index,   | into block
//           | update_value, query_start, query_end      |
//  out      | out_valid, out_ready, range_minimum       | out of block
//  cfg      | cfg_we, leaf_count                        | into block
//
// An update writes the leaf, then climbs one level per cycle through the single
// read port and the shared min unit, writing each ancestor as it goes.
// A query climbs the tree level by level, then drains the last read and emits the result.
// After reset, and after every leaf_count write, a clearing pass writes the
// sentinel to 2*min(leaf_count, LEAVES) nodes, one per cycle; no item is taken then.
// A finished result waits in the output register while the next item is taken.
`default_nettype none

module range_min_segment_tree_unit #(
	parameter int LEAVES = 1024
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic                                  mode,
	input  wire logic [rmst_pkg::IDX_W-1:0]            update_index,
	input  wire logic signed [rmst_pkg::VAL_W-1:0]     update_value,
	input  wire logic [rmst_pkg::CFG_W-1:0]            query_start,
	input  wire logic [rmst_pkg::CFG_W-1:0]            query_end,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [rmst_pkg::VAL_W-1:0]          range_minimum,
	input  wire logic                                  cfg_we,
	input  wire logic [rmst_pkg::CFG_W-1:0]            leaf_count
);

	localparam int DEPTH    = 2 * LEAVES;
	localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW       = rmst_pkg::NODE_W;
	localparam int XW       = (AW > NW) ? AW : NW;
	localparam int CFG_MAX  = (1 << rmst_pkg::CFG_W) - 1;
	localparam int LEAF_CAP = (LEAVES < CFG_MAX) ? LEAVES : CFG_MAX;
	localparam logic [rmst_pkg::CFG_W-1:0] LEAF_CAP_V = rmst_pkg::CFG_W'(LEAF_CAP);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ULEAF,
		ST_ULVL,
		ST_QRY,
		ST_QDONE
	} state_t;

	state_t                               state_q;
	logic [rmst_pkg::CFG_W-1:0]           leaf_count_q;
	logic                                 clearing_q;
	logic [NW-1:0]                        clr_cnt_q;
	logic [NW-1:0]                        node_q;
	logic [NW-1:0]                        lo_q;
	logic [NW-1:0]                        hi_q;
	logic                                 rd_pend_q;
	logic signed [rmst_pkg::VAL_W-1:0]    acc_q;
	logic                                 out_valid_q;
	logic signed [rmst_pkg::VAL_W-1:0]    result_q;

	logic signed [rmst_pkg::VAL_W-1:0]    mem [DEPTH];
	logic signed [rmst_pkg::VAL_W-1:0]    rdata_q;

	logic [rmst_pkg::CFG_W-1:0]           n_eff;
	logic [NW-1:0]                        n_node;
	logic [rmst_pkg::CFG_W-1:0]           lo_clamp;
	logic [rmst_pkg::CFG_W-1:0]           hi_clamp;
	logic [NW-1:0]                        parent;
	logic [NW-1:0]                        lo_inc;
	logic [NW-1:0]                        hi_dec;
	logic                                 accept;
	logic                                 out_free;
	logic signed [rmst_pkg::VAL_W-1:0]    min_y;

	logic                                 we;
	logic [NW-1:0]                        wnode;
	logic signed [rmst_pkg::VAL_W-1:0]    wdata;
	logic [NW-1:0]                        rnode;
	logic [XW-1:0]                        wnode_x;
	logic [XW-1:0]                        rnode_x;
	logic [AW-1:0]                        waddr;
	logic [AW-1:0]                        raddr;

	assign n_eff    = (leaf_count_q > LEAF_CAP_V) ? LEAF_CAP_V : leaf_count_q;
	assign n_node   = {1'b0, n_eff};
	assign lo_clamp = (query_start > n_eff) ? n_eff : query_start;
	assign hi_clamp = (query_end > n_eff) ? n_eff : query_end;
	assign parent   = node_q >> 1;
	assign lo_inc   = lo_q + NW'(1);
	assign hi_dec   = hi_q - NW'(1);

	assign in_ready  = (state_q == ST_IDLE) && !clearing_q;
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign range_minimum = result_q;

	rmst_min_unit u_min (
		.a (acc_q),
		.b (rdata_q),
		.y (min_y)
	);

	// Store port selection: clearing pass, leaf write, ancestor write, sibling and query reads.
	always_comb begin
		we    = 1'b0;
		wnode = clr_cnt_q;
		wdata = rmst_pkg::SENTINEL;
		rnode = '0;
		if (clearing_q) begin
			we = (clr_cnt_q < {n_eff, 1'b0});
		end else begin
			case (state_q)
				ST_ULEAF: begin
					we    = 1'b1;
					wnode = node_q;
					wdata = acc_q;
					rnode = node_q ^ NW'(1);
				end
				ST_ULVL: begin
					we    = 1'b1;
					wnode = parent;
					wdata = min_y;
					rnode = parent ^ NW'(1);
				end
				ST_QRY: begin
					if (lo_q[0]) begin
						rnode = lo_q;
					end else begin
						rnode = hi_dec;
					end
				end
				default: begin
					rnode = '0;
				end
			endcase
		end
	end

	assign wnode_x = XW'(wnode);
	assign rnode_x = XW'(rnode);
	assign waddr   = wnode_x[AW-1:0];
	assign raddr   = rnode_x[AW-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			leaf_count_q <= rmst_pkg::LEAF_RESET;
			clearing_q   <= 1'b1;
			clr_cnt_q    <= '0;
			rd_pend_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			node_q       <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			acc_q        <= rmst_pkg::SENTINEL;
			result_q     <= rmst_pkg::SENTINEL;
		end else begin
			// a new result may land in the same cycle the old one is taken
			if ((state_q == ST_QDONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				leaf_count_q <= leaf_count;
				clearing_q   <= 1'b1;
				clr_cnt_q    <= '0;
			end else if (clearing_q) begin
				if (clr_cnt_q < {n_eff, 1'b0}) begin
					clr_cnt_q <= clr_cnt_q + NW'(1);
				end else begin
					clearing_q <= 1'b0;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (mode == rmst_pkg::MODE_UPDATE) begin
							if ({1'b0, update_index} < n_eff) begin
								node_q  <= NW'(update_index) + n_node;
								acc_q   <= update_value;
								state_q <= ST_ULEAF;
							end
						end else begin
							lo_q      <= {1'b0, lo_clamp} + n_node;
							hi_q      <= {1'b0, hi_clamp} + n_node;
							acc_q     <= rmst_pkg::SENTINEL;
							rd_pend_q <= 1'b0;
							state_q   <= ST_QRY;
						end
					end
				end
				ST_ULEAF: begin
					// leaf written this cycle; sibling read is in flight
					if (node_q > NW'(1)) begin
						state_q <= ST_ULVL;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_ULVL: begin
					acc_q  <= min_y;
					node_q <= parent;
					if (parent <= NW'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_QRY: begin
					if (rd_pend_q) begin
						acc_q <= min_y;
					end
					if (lo_q < hi_q) begin
						rd_pend_q <= lo_q[0] | hi_q[0];
						if (lo_q[0] && hi_q[0]) begin
							// both ends odd: take the left node now, the right one next cycle
							lo_q <= lo_inc;
						end else if (lo_q[0]) begin
							lo_q <= lo_inc >> 1;
							hi_q <= hi_q >> 1;
						end else begin
							lo_q <= lo_q >> 1;
							hi_q <= hi_q >> 1;
						end
					end else begin
						rd_pend_q <= 1'b0;
						state_q   <= ST_QDONE;
					end
				end
				ST_QDONE: begin
					if (out_free) begin
						result_q <= acc_q;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_idle_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> (state_q == ST_IDLE))
		else $error("sequencer active during clearing pass");

	a_no_read_left_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_QDONE) |-> !rd_pend_q)
		else $error("query finished with an unfolded node read");

	a_level_has_parent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ULVL) |-> (node_q > NW'(1)))
		else $error("ancestor step at or above the root");

	a_result_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_QDONE))
		else $error("result produced outside a finished query");
`endif

endmodule

`default_nettype wire
